>>> src/sgi3d_pkg.sv
// ============================================================================
// sgi3d_pkg: shared constants for the 3D segment intersection block
// Holds the default coordinate width used by the channel interfaces and
// the top level.
// ============================================================================
package sgi3d_pkg;

    // Default width of one signed endpoint coordinate.
    localparam int COORD_WIDTH = 16;

endpackage

>>> src/sgi3d_if.sv
// ============================================================================
// sgi3d_if: valid/ready channels of the 3D segment intersection block
// sgi3d_seg_if carries one pair of segments per item, sgi3d_res_if carries
// the two result flags per item.
// ============================================================================
interface sgi3d_seg_if #(
    parameter int COORD_WIDTH = sgi3d_pkg::COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] seg_a_start_x;
    logic signed [COORD_WIDTH-1:0] seg_a_start_y;
    logic signed [COORD_WIDTH-1:0] seg_a_start_z;
    logic signed [COORD_WIDTH-1:0] seg_a_end_x;
    logic signed [COORD_WIDTH-1:0] seg_a_end_y;
    logic signed [COORD_WIDTH-1:0] seg_a_end_z;
    logic signed [COORD_WIDTH-1:0] seg_b_start_x;
    logic signed [COORD_WIDTH-1:0] seg_b_start_y;
    logic signed [COORD_WIDTH-1:0] seg_b_start_z;
    logic signed [COORD_WIDTH-1:0] seg_b_end_x;
    logic signed [COORD_WIDTH-1:0] seg_b_end_y;
    logic signed [COORD_WIDTH-1:0] seg_b_end_z;

    modport source (
        output valid,
        output seg_a_start_x, seg_a_start_y, seg_a_start_z,
        output seg_a_end_x, seg_a_end_y, seg_a_end_z,
        output seg_b_start_x, seg_b_start_y, seg_b_start_z,
        output seg_b_end_x, seg_b_end_y, seg_b_end_z,
        input  ready
    );

    modport sink (
        input  valid,
        input  seg_a_start_x, seg_a_start_y, seg_a_start_z,
        input  seg_a_end_x, seg_a_end_y, seg_a_end_z,
        input  seg_b_start_x, seg_b_start_y, seg_b_start_z,
        input  seg_b_end_x, seg_b_end_y, seg_b_end_z,
        output ready
    );
endinterface

interface sgi3d_res_if;
    logic valid;
    logic ready;
    logic segments_meet;
    logic directions_parallel;

    modport source (
        output valid,
        output segments_meet,
        output directions_parallel,
        input  ready
    );

    modport sink (
        input  valid,
        input  segments_meet,
        input  directions_parallel,
        output ready
    );
endinterface

>>> src/segment_intersection_3d_top.sv
// ============================================================================
// segment_intersection_3d_top: exact 3D segment/segment intersection test
// Six-stage pipeline that decides, with exact integer arithmetic, whether
// two closed 3D segments share a point and whether they are parallel.
// ============================================================================
// The block takes one pair of segments per clock cycle while the result
// side does not stall, and returns one result item per input item, in
// order. Throughput is one item per cycle when not stalled; it is set by the
// six-register pipeline, in which every stage holds its own valid bit and
// moves forward whenever the stage after it is empty or moving, so bubbles
// are squeezed out and a stall on the result side loses nothing.
// The test is exact. With d = A1 - A0, e = B1 - B0, w = B0 - A0 and
// n = d x e, the segments count as parallel when n is zero, and then they
// meet when B0 or B1 lies on A or A0 lies on B. Otherwise they meet when w
// is coplanar with d and e (w . n is zero) and both line parameters fall in
// [0, 1]. For coplanar lines w x e = t*n and w x d = s*n, so t and s are
// checked against any nonzero component of n by sign and magnitude compares,
// with no division. Stage 1 forms the coordinate differences, stage 2 the
// products of the cross and dot products, stage 3 the cross components and
// the point-on-segment tests, stage 4 the parameter range checks and the
// split products of w . n, stage 5 the partial sums and stage 6 the final
// add, the zero test and the result register.
module segment_intersection_3d_top #(
    parameter int COORD_WIDTH = sgi3d_pkg::COORD_WIDTH
) (
    input  logic         clk,
    input  logic         rst_n,
    sgi3d_seg_if.sink    seg_in,
    sgi3d_res_if.source  result_out
);

    localparam int NUM_STAGES = 6;
    // Coordinate differences.
    localparam int D_W    = COORD_WIDTH + 1;
    // Product of two differences.
    localparam int P_W    = 2 * D_W;
    // One cross product component.
    localparam int C_W    = P_W + 1;
    // Sum of three products of differences.
    localparam int S_W    = P_W + 2;
    // The cross components of n are split into an unsigned low part and a
    // signed high part so that w . n needs no multiplier wider than 17x19.
    localparam int LO_W   = COORD_WIDTH + 2;
    localparam int HI_W   = C_W - LO_W;
    localparam int PLO_W  = D_W + LO_W + 1;
    localparam int PHI_W  = D_W + HI_W;
    localparam int LS_W   = PLO_W + 2;
    localparam int HS_W   = PHI_W + 2;
    localparam int DOT_W  = D_W + C_W + 2;

    // ------------------------------------------------------------------------
    // Pipeline control: a stage advances when it is empty or its successor
    // advances.
    // ------------------------------------------------------------------------
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] adv;

    always_comb
    begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || result_out.ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= seg_in.valid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign seg_in.ready     = adv[0];
    assign result_out.valid = valid_reg[NUM_STAGES-1];

    // ------------------------------------------------------------------------
    // Stage 1: coordinate differences.
    // ------------------------------------------------------------------------
    logic signed [COORD_WIDTH-1:0] a0 [3];
    logic signed [COORD_WIDTH-1:0] a1 [3];
    logic signed [COORD_WIDTH-1:0] b0 [3];
    logic signed [COORD_WIDTH-1:0] b1 [3];

    assign a0[0] = seg_in.seg_a_start_x;
    assign a0[1] = seg_in.seg_a_start_y;
    assign a0[2] = seg_in.seg_a_start_z;
    assign a1[0] = seg_in.seg_a_end_x;
    assign a1[1] = seg_in.seg_a_end_y;
    assign a1[2] = seg_in.seg_a_end_z;
    assign b0[0] = seg_in.seg_b_start_x;
    assign b0[1] = seg_in.seg_b_start_y;
    assign b0[2] = seg_in.seg_b_start_z;
    assign b1[0] = seg_in.seg_b_end_x;
    assign b1[1] = seg_in.seg_b_end_y;
    assign b1[2] = seg_in.seg_b_end_z;

    logic signed [D_W-1:0] s1_d_reg [3];
    logic signed [D_W-1:0] s1_e_reg [3];
    logic signed [D_W-1:0] s1_w_reg [3];
    // Point-on-segment tests: B0 on A, B1 on A, A0 on B.
    logic signed [D_W-1:0] s1_u_reg [3][3];
    logic signed [D_W-1:0] s1_v_reg [3][3];

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int k = 0; k < 3; k++)
            begin
                s1_d_reg[k]    <= D_W'(a1[k]) - D_W'(a0[k]);
                s1_e_reg[k]    <= D_W'(b1[k]) - D_W'(b0[k]);
                s1_w_reg[k]    <= D_W'(b0[k]) - D_W'(a0[k]);
                s1_u_reg[0][k] <= D_W'(a0[k]) - D_W'(b0[k]);
                s1_v_reg[0][k] <= D_W'(a1[k]) - D_W'(b0[k]);
                s1_u_reg[1][k] <= D_W'(a0[k]) - D_W'(b1[k]);
                s1_v_reg[1][k] <= D_W'(a1[k]) - D_W'(b1[k]);
                s1_u_reg[2][k] <= D_W'(b0[k]) - D_W'(a0[k]);
                s1_v_reg[2][k] <= D_W'(b1[k]) - D_W'(a0[k]);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: all products. Cross component k is a[k+1]*b[k+2] minus
    // a[k+2]*b[k+1], indices taken modulo three.
    // ------------------------------------------------------------------------
    logic signed [P_W-1:0] s2_npos_reg  [3];
    logic signed [P_W-1:0] s2_nneg_reg  [3];
    logic signed [P_W-1:0] s2_wepos_reg [3];
    logic signed [P_W-1:0] s2_weneg_reg [3];
    logic signed [P_W-1:0] s2_wdpos_reg [3];
    logic signed [P_W-1:0] s2_wdneg_reg [3];
    logic signed [P_W-1:0] s2_uvpos_reg [3][3];
    logic signed [P_W-1:0] s2_uvneg_reg [3][3];
    logic signed [P_W-1:0] s2_uvdot_reg [3][3];
    logic signed [D_W-1:0] s2_w_reg     [3];

    for (genvar k = 0; k < 3; k++)
    begin : g_s2
        localparam int K1 = (k + 1) % 3;
        localparam int K2 = (k + 2) % 3;

        always_ff @(posedge clk)
        begin
            if (adv[1])
            begin
                s2_npos_reg[k]  <= P_W'(s1_d_reg[K1]) * P_W'(s1_e_reg[K2]);
                s2_nneg_reg[k]  <= P_W'(s1_d_reg[K2]) * P_W'(s1_e_reg[K1]);
                s2_wepos_reg[k] <= P_W'(s1_w_reg[K1]) * P_W'(s1_e_reg[K2]);
                s2_weneg_reg[k] <= P_W'(s1_w_reg[K2]) * P_W'(s1_e_reg[K1]);
                s2_wdpos_reg[k] <= P_W'(s1_w_reg[K1]) * P_W'(s1_d_reg[K2]);
                s2_wdneg_reg[k] <= P_W'(s1_w_reg[K2]) * P_W'(s1_d_reg[K1]);
                s2_w_reg[k]     <= s1_w_reg[k];
            end
        end

        for (genvar t = 0; t < 3; t++)
        begin : g_uv
            always_ff @(posedge clk)
            begin
                if (adv[1])
                begin
                    s2_uvpos_reg[t][k] <= P_W'(s1_u_reg[t][K1]) * P_W'(s1_v_reg[t][K2]);
                    s2_uvneg_reg[t][k] <= P_W'(s1_u_reg[t][K2]) * P_W'(s1_v_reg[t][K1]);
                    s2_uvdot_reg[t][k] <= P_W'(s1_u_reg[t][k]) * P_W'(s1_v_reg[t][k]);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: cross components and the parallel-case meet decision.
    // A point lies on a segment when the vectors to both ends have a zero
    // cross product and a dot product that is not positive.
    // ------------------------------------------------------------------------
    logic [2:0]            on_seg;
    logic signed [S_W-1:0] uv_sum [3];
    logic                  uv_cross_zero [3];

    always_comb
    begin
        for (int t = 0; t < 3; t++)
        begin
            uv_sum[t] = S_W'(s2_uvdot_reg[t][0]) + S_W'(s2_uvdot_reg[t][1])
                      + S_W'(s2_uvdot_reg[t][2]);
            uv_cross_zero[t] = (s2_uvpos_reg[t][0] == s2_uvneg_reg[t][0])
                            && (s2_uvpos_reg[t][1] == s2_uvneg_reg[t][1])
                            && (s2_uvpos_reg[t][2] == s2_uvneg_reg[t][2]);
            on_seg[t] = uv_cross_zero[t] && (uv_sum[t][S_W-1] || uv_sum[t] == '0);
        end
    end

    logic signed [C_W-1:0] s3_n_reg   [3];
    logic signed [C_W-1:0] s3_cwe_reg [3];
    logic signed [C_W-1:0] s3_cwd_reg [3];
    logic signed [D_W-1:0] s3_w_reg   [3];
    logic                  s3_mp_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            for (int k = 0; k < 3; k++)
            begin
                s3_n_reg[k]   <= C_W'(s2_npos_reg[k]) - C_W'(s2_nneg_reg[k]);
                s3_cwe_reg[k] <= C_W'(s2_wepos_reg[k]) - C_W'(s2_weneg_reg[k]);
                s3_cwd_reg[k] <= C_W'(s2_wdpos_reg[k]) - C_W'(s2_wdneg_reg[k]);
                s3_w_reg[k]   <= s2_w_reg[k];
            end
            s3_mp_reg <= |on_seg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 4: parameter range checks against the first nonzero component
    // of n, and the split products of w . n.
    // ------------------------------------------------------------------------
    logic signed [C_W-1:0] sel_n;
    logic signed [C_W-1:0] sel_t;
    logic signed [C_W-1:0] sel_s;
    logic                  par;
    logic                  t_ok;
    logic                  s_ok;

    always_comb
    begin
        sel_n = s3_n_reg[2];
        sel_t = s3_cwe_reg[2];
        sel_s = s3_cwd_reg[2];
        if (s3_n_reg[1] != '0)
        begin
            sel_n = s3_n_reg[1];
            sel_t = s3_cwe_reg[1];
            sel_s = s3_cwd_reg[1];
        end
        if (s3_n_reg[0] != '0)
        begin
            sel_n = s3_n_reg[0];
            sel_t = s3_cwe_reg[0];
            sel_s = s3_cwd_reg[0];
        end
        par = (s3_n_reg[0] == '0) && (s3_n_reg[1] == '0) && (s3_n_reg[2] == '0);
        // The parameter is c / n_k; it lies in [0, 1] when c has the sign of
        // n_k (or is zero) and does not exceed it in magnitude.
        if (!sel_n[C_W-1])
        begin
            t_ok = !sel_t[C_W-1] && (sel_t <= sel_n);
            s_ok = !sel_s[C_W-1] && (sel_s <= sel_n);
        end
        else
        begin
            t_ok = (sel_t[C_W-1] || sel_t == '0) && (sel_t >= sel_n);
            s_ok = (sel_s[C_W-1] || sel_s == '0) && (sel_s >= sel_n);
        end
    end

    logic signed [PLO_W-1:0] s4_plo_reg [3];
    logic signed [PHI_W-1:0] s4_phi_reg [3];
    logic                    s4_par_reg;
    logic                    s4_mp_reg;
    logic                    s4_t_ok_reg;
    logic                    s4_s_ok_reg;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            for (int k = 0; k < 3; k++)
            begin
                s4_plo_reg[k] <= PLO_W'(s3_w_reg[k])
                               * PLO_W'($signed({1'b0, s3_n_reg[k][LO_W-1:0]}));
                s4_phi_reg[k] <= PHI_W'(s3_w_reg[k])
                               * PHI_W'($signed(s3_n_reg[k][C_W-1:LO_W]));
            end
            s4_par_reg  <= par;
            s4_mp_reg   <= s3_mp_reg;
            s4_t_ok_reg <= t_ok;
            s4_s_ok_reg <= s_ok;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 5: partial sums of the low and high halves of w . n.
    // ------------------------------------------------------------------------
    logic signed [LS_W-1:0] s5_lo_sum_reg;
    logic signed [HS_W-1:0] s5_hi_sum_reg;
    logic                   s5_par_reg;
    logic                   s5_mp_reg;
    logic                   s5_t_ok_reg;
    logic                   s5_s_ok_reg;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s5_lo_sum_reg <= LS_W'(s4_plo_reg[0]) + LS_W'(s4_plo_reg[1])
                           + LS_W'(s4_plo_reg[2]);
            s5_hi_sum_reg <= HS_W'(s4_phi_reg[0]) + HS_W'(s4_phi_reg[1])
                           + HS_W'(s4_phi_reg[2]);
            s5_par_reg    <= s4_par_reg;
            s5_mp_reg     <= s4_mp_reg;
            s5_t_ok_reg   <= s4_t_ok_reg;
            s5_s_ok_reg   <= s4_s_ok_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 6: coplanarity test and the result register.
    // ------------------------------------------------------------------------
    logic signed [DOT_W-1:0] wn_dot;
    logic                    meet_next;

    always_comb
    begin
        wn_dot = (DOT_W'(s5_hi_sum_reg) <<< LO_W) + DOT_W'(s5_lo_sum_reg);
        if (s5_par_reg)
        begin
            meet_next = s5_mp_reg;
        end
        else
        begin
            meet_next = (wn_dot == '0) && s5_t_ok_reg && s5_s_ok_reg;
        end
    end

    logic s6_meet_reg;
    logic s6_par_reg;

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s6_meet_reg <= meet_next;
            s6_par_reg  <= s5_par_reg;
        end
    end

    assign result_out.segments_meet       = s6_meet_reg;
    assign result_out.directions_parallel = s6_par_reg;

endmodule

>>> tb/tb.sv
// ============================================================================
// tb: self-checking bench for the 3D segment intersection block
// Drives pairs of segments through the valid/ready input channel, predicts
// both result flags with exact wide integer arithmetic and checks every
// result item in order, under several patterns of sender and receiver idling.
// ============================================================================
module tb;

    localparam int CW          = sgi3d_pkg::COORD_WIDTH;
    // Cycles without any handshake on either channel before the run is
    // declared hung. A correct block never comes close to this.
    localparam int QUIET_LIMIT = 1000;
    // Cycles left after the last result, well beyond the six-stage latency,
    // so that a spurious extra result item would still be caught.
    localparam int TAIL_CYCLES = 16;

    // One accepted item as twelve raw coordinates, index 0 being seg_a_start_x
    // and index 11 being seg_b_end_z.
    typedef logic [11:0][CW-1:0] pair_t;

    // Products of two 17-bit differences and their sums need about 75 bits,
    // so 128 bits keeps every cross and dot product exact.
    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        wide_t x;
        wide_t y;
        wide_t z;
    } vec_t;

    // Integer point used while building stimulus.
    typedef struct packed {
        int x;
        int y;
        int z;
    } point_t;

    typedef struct packed {
        logic meet;
        logic par;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n;

    sgi3d_seg_if #(.COORD_WIDTH(CW)) seg_if ();
    sgi3d_res_if                     res_if ();

    segment_intersection_3d_top #(.COORD_WIDTH(CW)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .seg_in     (seg_if),
        .result_out (res_if)
    );

    // Flags predicted for accepted items whose result has not arrived yet.
    verdict_t pending_verdicts[$];
    int       mismatch_count = 0;
    int       quiet_cycles   = 0;
    int       src_idle_pct   = 0;
    int       sink_stall_pct = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Exact predictor. Coordinates are sign-extended to 128 bits, so no zero
    // test or sign test can be upset by overflow.
    // ------------------------------------------------------------------------
    function automatic vec_t widen(pair_t p, int base);
        vec_t r;
        r.x = wide_t'($signed(p[base]));
        r.y = wide_t'($signed(p[base + 1]));
        r.z = wide_t'($signed(p[base + 2]));
        return r;
    endfunction

    function automatic vec_t vsub(vec_t a, vec_t b);
        vec_t r;
        r.x = a.x - b.x;
        r.y = a.y - b.y;
        r.z = a.z - b.z;
        return r;
    endfunction

    function automatic vec_t vcross(vec_t a, vec_t b);
        vec_t r;
        r.x = a.y * b.z - a.z * b.y;
        r.y = a.z * b.x - a.x * b.z;
        r.z = a.x * b.y - a.y * b.x;
        return r;
    endfunction

    function automatic wide_t vdot(vec_t a, vec_t b);
        wide_t r;
        r = a.x * b.x + a.y * b.y + a.z * b.z;
        return r;
    endfunction

    // A point q lies on the closed segment [p0, p1] when the vectors to both
    // ends are collinear and point in opposite directions (or one is zero).
    function automatic logic on_segment(vec_t p0, vec_t p1, vec_t q);
        vec_t  u;
        vec_t  v;
        wide_t d;
        u = vsub(p0, q);
        v = vsub(p1, q);
        if (vcross(u, v) != '0)
        begin
            return 1'b0;
        end
        d = vdot(u, v);
        return d <= 0;
    endfunction

    // True when 0 <= num / den <= 1 for a positive den, without a division.
    function automatic logic in_unit(wide_t num, wide_t den);
        wide_t rest;
        rest = den - num;
        return (num >= 0) && (rest >= 0);
    endfunction

    function automatic verdict_t predict_verdict(pair_t p);
        vec_t     a0, a1, b0, b1, d, e, n, w;
        wide_t    nn;
        verdict_t v;
        a0 = widen(p, 0);
        a1 = widen(p, 3);
        b0 = widen(p, 6);
        b1 = widen(p, 9);
        d = vsub(a1, a0);
        e = vsub(b1, b0);
        n = vcross(d, e);
        v.par = (n == '0);
        if (v.par)
        begin
            // Parallel, collinear or degenerate: meet only through an
            // endpoint lying on the other segment.
            v.meet = on_segment(a0, a1, b0) || on_segment(a0, a1, b1) ||
                     on_segment(b0, b1, a0);
        end
        else
        begin
            // Lines must be coplanar and both line parameters in [0, 1].
            w = vsub(b0, a0);
            nn = vdot(n, n);
            v.meet = (vdot(w, n) == 0) &&
                     in_unit(vdot(vcross(w, e), n), nn) &&
                     in_unit(vdot(vcross(w, d), n), nn);
        end
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker and input monitor. Both run in one process at the rising
    // edge, so a result is always compared before an item accepted at the
    // same edge is added to the pending list.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $error("result item arrived with no input item pending");
                    mismatch_count++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (res_if.segments_meet !== want.meet)
                    begin
                        $error("segments_meet: expected %0b, actual %0b",
                               want.meet, res_if.segments_meet);
                        mismatch_count++;
                    end
                    if (res_if.directions_parallel !== want.par)
                    begin
                        $error("directions_parallel: expected %0b, actual %0b",
                               want.par, res_if.directions_parallel);
                        mismatch_count++;
                    end
                end
            end
            if (seg_if.valid && seg_if.ready)
            begin
                pending_verdicts.push_back(predict_verdict({
                    seg_if.seg_b_end_z,   seg_if.seg_b_end_y,   seg_if.seg_b_end_x,
                    seg_if.seg_b_start_z, seg_if.seg_b_start_y, seg_if.seg_b_start_x,
                    seg_if.seg_a_end_z,   seg_if.seg_a_end_y,   seg_if.seg_a_end_x,
                    seg_if.seg_a_start_z, seg_if.seg_a_start_y, seg_if.seg_a_start_x}));
            end
        end
    end

    // The receiver stalls at random, changing ready only at the falling edge.
    always @(negedge clk)
    begin
        res_if.ready = ($urandom_range(99) >= sink_stall_pct);
    end

    // Watchdog: counts cycles in which neither channel moves an item.
    always @(posedge clk)
    begin
        if (!rst_n || (seg_if.valid && seg_if.ready) || (res_if.valid && res_if.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic int rand_int(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic point_t pt(int x, int y, int z);
        point_t r;
        r.x = x;
        r.y = y;
        r.z = z;
        return r;
    endfunction

    function automatic point_t rand_pt(int span);
        return pt(rand_int(-span, span), rand_int(-span, span), rand_int(-span, span));
    endfunction

    function automatic point_t pt_add(point_t a, point_t b);
        return pt(a.x + b.x, a.y + b.y, a.z + b.z);
    endfunction

    function automatic point_t pt_scale(point_t a, int k);
        return pt(a.x * k, a.y * k, a.z * k);
    endfunction

    // Short, medium and long direction vectors, so that exact hits on grid
    // points are common while large products are still exercised.
    function automatic int pick_span();
        case ($urandom_range(2))
            0:       return 3;
            1:       return 40;
            default: return 1000;
        endcase
    endfunction

    // Sends one item: idles at random first, then holds valid until the
    // block takes the item. Every call starts at a falling edge, so valid is
    // lowered or replaced before the next rising edge.
    task automatic send_segments(point_t a_start, point_t a_end,
                                 point_t b_start, point_t b_end);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            seg_if.valid = 1'b0;
            @(negedge clk);
        end
        seg_if.valid         = 1'b1;
        seg_if.seg_a_start_x = a_start.x[CW-1:0];
        seg_if.seg_a_start_y = a_start.y[CW-1:0];
        seg_if.seg_a_start_z = a_start.z[CW-1:0];
        seg_if.seg_a_end_x   = a_end.x[CW-1:0];
        seg_if.seg_a_end_y   = a_end.y[CW-1:0];
        seg_if.seg_a_end_z   = a_end.z[CW-1:0];
        seg_if.seg_b_start_x = b_start.x[CW-1:0];
        seg_if.seg_b_start_y = b_start.y[CW-1:0];
        seg_if.seg_b_start_z = b_start.z[CW-1:0];
        seg_if.seg_b_end_x   = b_end.x[CW-1:0];
        seg_if.seg_b_end_y   = b_end.y[CW-1:0];
        seg_if.seg_b_end_z   = b_end.z[CW-1:0];
        do
        begin
            @(posedge clk);
        end
        while (!seg_if.ready);
    endtask

    // Stops sending and waits until every pending result has come back.
    task automatic wait_for_results();
        @(negedge clk);
        seg_if.valid = 1'b0;
        while (pending_verdicts.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------------

    // Coordinates at both ends of the range and alternating bit patterns.
    task automatic test_extremes();
        // Main diagonals of the full cube cross at a point off the grid.
        send_segments(pt(-32768, -32768, -32768), pt(32767, 32767, 32767),
                      pt(32767, -32768, -32768), pt(-32768, 32767, 32767));
        // Two points both at the origin.
        send_segments(pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0), pt(0, 0, 0));
        // Two points at opposite corners.
        send_segments(pt(-32768, -32768, -32768), pt(-32768, -32768, -32768),
                      pt(32767, 32767, 32767), pt(32767, 32767, 32767));
        // A full-length diagonal and a collinear piece of it on 0x5555/0xAAAA.
        send_segments(pt(32767, -32768, 32767), pt(-32768, 32767, -32768),
                      pt(21845, -21846, 21845), pt(-21846, 21845, -21846));
    endtask

    // Segments that have collapsed to a single point.
    task automatic test_degenerate_points();
        // Point at the middle of the other segment.
        send_segments(pt(0, 0, 0), pt(10, 10, 10), pt(5, 5, 5), pt(5, 5, 5));
        // Point one step off the segment.
        send_segments(pt(0, 0, 0), pt(10, 10, 10), pt(5, 5, 6), pt(5, 5, 6));
        // Point on the line just beyond the end of the segment.
        send_segments(pt(0, 0, 0), pt(10, 10, 10), pt(11, 11, 11), pt(11, 11, 11));
        // Point exactly on an endpoint.
        send_segments(pt(0, 0, 0), pt(10, 10, 10), pt(10, 10, 10), pt(10, 10, 10));
        // The first segment is the point, lying inside the second one.
        send_segments(pt(3, 0, 0), pt(3, 0, 0), pt(0, 0, 0), pt(8, 0, 0));
    endtask

    // Parallel and collinear segment pairs.
    task automatic test_parallel_and_collinear();
        send_segments(pt(0, 0, 0), pt(10, 0, 0), pt(5, 0, 0), pt(20, 0, 0));
        // Collinear, touching at one endpoint only.
        send_segments(pt(0, 0, 0), pt(10, 0, 0), pt(10, 0, 0), pt(20, 0, 0));
        // Collinear with a gap of one grid step.
        send_segments(pt(0, 0, 0), pt(10, 0, 0), pt(11, 0, 0), pt(20, 0, 0));
        // Parallel on distinct lines.
        send_segments(pt(0, 0, 0), pt(10, 0, 0), pt(0, 1, 0), pt(10, 1, 0));
        // The same segment in reverse direction.
        send_segments(pt(0, 0, 0), pt(10, 0, 0), pt(10, 0, 0), pt(0, 0, 0));
        // The second segment contains the first, so only A0 lies on B.
        send_segments(pt(2, 2, 2), pt(4, 4, 4), pt(0, 0, 0), pt(9, 9, 9));
    endtask

    // Non-parallel pairs: crossings, touches, near misses and skew lines.
    task automatic test_crossing_and_skew();
        send_segments(pt(-5, 0, 0), pt(5, 0, 0), pt(0, -5, 0), pt(0, 5, 0));
        // The start of B touches the inside of A.
        send_segments(pt(-5, 0, 0), pt(5, 0, 0), pt(0, 0, 0), pt(0, 7, 0));
        // The end of A meets the start of B.
        send_segments(pt(0, 0, 0), pt(4, 0, 0), pt(4, 0, 0), pt(4, 3, 3));
        // Lines cross just beyond the end of A.
        send_segments(pt(-5, 0, 0), pt(5, 0, 0), pt(6, -5, 0), pt(6, 5, 0));
        // Lines cross just before the start of B.
        send_segments(pt(-5, 0, 0), pt(5, 0, 0), pt(0, 1, 0), pt(0, 5, 0));
        // Skew lines one step apart.
        send_segments(pt(-5, 0, 0), pt(5, 0, 0), pt(0, -5, 1), pt(0, 5, 1));
        // Long skew diagonals one step apart.
        send_segments(pt(-30000, -30000, 0), pt(30000, 30000, 0),
                      pt(-30000, 30000, 1), pt(30000, -30000, 1));
    endtask

    // ------------------------------------------------------------------------
    // Random tests.
    // ------------------------------------------------------------------------

    // Both segments in the plane spanned by d and v through A0, so the
    // coplanar branch is reached and the parameter checks decide the result.
    task automatic test_random_coplanar(int count);
        point_t a0, d, v;
        int     span;
        repeat (count)
        begin
            span = pick_span();
            a0 = rand_pt(8000);
            d = rand_pt(span);
            v = rand_pt(span);
            send_segments(a0, pt_add(a0, d),
                pt_add(a0, pt_add(pt_scale(d, rand_int(-2, 3)), pt_scale(v, rand_int(-3, 3)))),
                pt_add(a0, pt_add(pt_scale(d, rand_int(-2, 3)), pt_scale(v, rand_int(-3, 3)))));
        end
    endtask

    // Segments through a common grid point, sometimes with one endpoint
    // nudged by a unit so that the pair just misses or turns skew.
    task automatic test_random_crossing(int count);
        point_t p, u, v, b1;
        int     span;
        repeat (count)
        begin
            span = pick_span();
            p = rand_pt(8000);
            u = rand_pt(span);
            v = rand_pt(span);
            b1 = pt_add(p, pt_scale(v, rand_int(0, 4)));
            if ($urandom_range(2) == 0)
            begin
                b1 = pt_add(b1, rand_pt(1));
            end
            send_segments(pt_add(p, pt_scale(u, -rand_int(0, 4))),
                          pt_add(p, pt_scale(u, rand_int(0, 4))),
                          pt_add(p, pt_scale(v, -rand_int(0, 4))), b1);
        end
    endtask

    // Parallel pairs: collinear overlaps, gaps and touches, parallel lines
    // and degenerate segments of length zero.
    task automatic test_random_parallel(int count);
        point_t a0, d, offset, b0;
        int     span;
        repeat (count)
        begin
            span = pick_span();
            a0 = rand_pt(8000);
            d = rand_pt(span);
            offset = ($urandom_range(1) == 0) ? pt(0, 0, 0) : rand_pt(span);
            b0 = pt_add(pt_add(a0, pt_scale(d, rand_int(-4, 4))), offset);
            send_segments(a0, pt_add(a0, pt_scale(d, rand_int(0, 3))),
                          b0, pt_add(b0, pt_scale(d, rand_int(-3, 3))));
        end
    endtask

    // Unrelated coordinates over the full range: mostly skew pairs, and
    // every bit of every coordinate field toggles.
    task automatic test_random_noise(int count);
        repeat (count)
        begin
            send_segments(pt($urandom, $urandom, $urandom), pt($urandom, $urandom, $urandom),
                          pt($urandom, $urandom, $urandom), pt($urandom, $urandom, $urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        seg_if.valid = 1'b0;
        seg_if.seg_a_start_x = '0; seg_if.seg_a_start_y = '0; seg_if.seg_a_start_z = '0;
        seg_if.seg_a_end_x   = '0; seg_if.seg_a_end_y   = '0; seg_if.seg_a_end_z   = '0;
        seg_if.seg_b_start_x = '0; seg_if.seg_b_start_y = '0; seg_if.seg_b_start_z = '0;
        seg_if.seg_b_end_x   = '0; seg_if.seg_b_end_y   = '0; seg_if.seg_b_end_z   = '0;
        res_if.ready = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed items run back to back with the receiver always ready.
        test_extremes();
        test_degenerate_points();
        test_parallel_and_collinear();
        test_crossing_and_skew();
        wait_for_results();

        // Random items under four idling patterns. The sender pauses after
        // each pattern until the pipeline has emptied completely.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct = 59;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct = 59;
                end
                default:
                begin
                    src_idle_pct = 31;
                    sink_stall_pct = 31;
                end
            endcase
            test_random_coplanar(130);
            test_random_crossing(100);
            test_random_parallel(90);
            test_random_noise(60);
            wait_for_results();
        end

        // Give a stray extra result item time to show up.
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
